// ===== rtl/core/pbrb_pkg.sv =====
package pbrb_pkg;

  localparam int DEPTH_DEFAULT        = 1024;
  localparam int MAX_TRANSFER_DEFAULT = 64;

  localparam int FUNC_W   = 2;
  localparam int DATA_W   = 8;
  localparam int AMOUNT_W = 7;
  localparam int LEVEL_W  = 10;

  localparam logic [FUNC_W-1:0] FUNC_PUT_REQ  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUT_BYTE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEEK     = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_GET      = 2'd3;

  typedef enum logic [1:0] {
    CMD_STATUS,
    CMD_WRITE,
    CMD_READ
  } cmd_kind_t;

  // Everything the back end needs for one command, except the ring address.
  typedef struct packed {
    cmd_kind_t            kind;
    logic                 ok;
    logic [DATA_W-1:0]    data;
    logic [AMOUNT_W-1:0]  count;
    logic [LEVEL_W-1:0]   fill;
    logic [LEVEL_W-1:0]   free;
  } cmd_info_t;

endpackage

// ===== rtl/core/pbrb_front.sv =====
module pbrb_front #(
  parameter int DEPTH        = pbrb_pkg::DEPTH_DEFAULT,
  parameter int MAX_TRANSFER = pbrb_pkg::MAX_TRANSFER_DEFAULT,
  parameter int AW           = $clog2(DEPTH)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [pbrb_pkg::FUNC_W-1:0]       in_func,
  input  logic [pbrb_pkg::DATA_W-1:0]       in_data,
  input  logic [pbrb_pkg::AMOUNT_W-1:0]     in_amount,
  output logic                              q_push,
  input  logic                              q_full,
  output pbrb_pkg::cmd_info_t               q_info,
  output logic [AW-1:0]                     q_addr
);
  import pbrb_pkg::*;

  localparam int CW = ((AW > AMOUNT_W) ? AW : AMOUNT_W) + 1;
  localparam int FW = (AW > LEVEL_W) ? AW : LEVEL_W;

  logic [AW-1:0]       wr_r, wr_nxt;
  logic [AW-1:0]       rd_r, rd_nxt;
  logic [AMOUNT_W-1:0] put_rem_r, put_rem_nxt;
  logic                accept;
  logic [AW-1:0]       fill_now, space_now, fill_new, space_new;
  logic [FW-1:0]       fill_ext, space_ext;
  logic                amt_in_range, fits_space, fits_fill;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  assign fill_now     = wr_r - rd_r;
  assign space_now    = rd_r - wr_r - AW'(1);
  assign amt_in_range = CW'(in_amount) <= CW'(MAX_TRANSFER);
  assign fits_space   = CW'(in_amount) <= CW'(space_now);
  assign fits_fill    = CW'(in_amount) <= CW'(fill_now);

  always_comb begin
    wr_nxt      = wr_r;
    rd_nxt      = rd_r;
    put_rem_nxt = put_rem_r;
    q_push      = 1'b0;
    q_info.kind = CMD_STATUS;
    q_info.ok   = 1'b0;
    q_info.data = in_data;
    q_info.count = in_amount;
    q_addr      = rd_r;
    if (accept) begin
      unique case (in_func)
        FUNC_PUT_REQ: begin
          q_push    = 1'b1;
          q_info.ok = amt_in_range && fits_space;
          put_rem_nxt = (amt_in_range && fits_space) ? in_amount : '0;
        end
        FUNC_PUT_BYTE: begin
          // A byte with no reservation behind it is dropped silently.
          if (put_rem_r != '0) begin
            q_push      = 1'b1;
            q_info.kind = CMD_WRITE;
            q_info.ok   = 1'b1;
            q_addr      = wr_r;
            wr_nxt      = wr_r + AW'(1);
            put_rem_nxt = put_rem_r - AMOUNT_W'(1);
          end
        end
        FUNC_PEEK, FUNC_GET: begin
          q_push = 1'b1;
          if (amt_in_range && fits_fill) begin
            q_info.ok = 1'b1;
            if (in_amount != '0) begin
              q_info.kind = CMD_READ;
              if (in_func == FUNC_GET) begin
                rd_nxt = rd_r + AW'(in_amount);
              end
            end
          end
        end
        default: ;
      endcase
    end
    fill_new    = wr_nxt - rd_nxt;
    space_new   = rd_nxt - wr_nxt - AW'(1);
    fill_ext    = FW'(fill_new);
    space_ext   = FW'(space_new);
    q_info.fill = fill_ext[LEVEL_W-1:0];
    q_info.free = space_ext[LEVEL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r      <= '0;
      rd_r      <= '0;
      put_rem_r <= '0;
    end else begin
      wr_r      <= wr_nxt;
      rd_r      <= rd_nxt;
      put_rem_r <= put_rem_nxt;
    end
  end

endmodule

// ===== rtl/core/pbrb_cmd_queue.sv =====
module pbrb_cmd_queue #(
  parameter int AW = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  pbrb_pkg::cmd_info_t  push_info,
  input  logic [AW-1:0]        push_addr,
  output logic                 valid,
  input  logic                 pop,
  output pbrb_pkg::cmd_info_t  head_info,
  output logic [AW-1:0]        head_addr
);
  import pbrb_pkg::*;

  localparam int DEPTH_Q = 2;

  cmd_info_t     info_r [DEPTH_Q];
  logic [AW-1:0] addr_r [DEPTH_Q];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          do_push, do_pop;

  assign full      = cnt_r == 2'(DEPTH_Q);
  assign valid     = cnt_r != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && valid;
  assign head_info = info_r[rp_r];
  assign head_addr = addr_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      info_r[wp_r] <= push_info;
      addr_r[wp_r] <= push_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (do_pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== rtl/core/pbrb_back.sv =====
module pbrb_back #(
  parameter int DEPTH = pbrb_pkg::DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  output logic                            q_pop,
  input  pbrb_pkg::cmd_info_t             q_info,
  input  logic [AW-1:0]                   q_addr,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic                            out_ok,
  output logic                            out_has_data,
  output logic [pbrb_pkg::DATA_W-1:0]     out_read_byte,
  output logic                            out_last,
  output logic [pbrb_pkg::LEVEL_W-1:0]    out_fill_level,
  output logic [pbrb_pkg::LEVEL_W-1:0]    out_free_space
);
  import pbrb_pkg::*;

  logic [DATA_W-1:0]   mem [DEPTH];
  logic [DATA_W-1:0]   rdata_r;
  logic [AMOUNT_W-1:0] idx_r, idx_nxt;
  logic                out_valid_r;
  logic                ok_r, has_data_r, last_r;
  logic [LEVEL_W-1:0]  fill_r, free_r;
  logic                step, is_read, is_write, run_last;
  logic [AW-1:0]       raddr;

  // The result register and the memory read register load together, so the
  // byte lines up with its flags without an extra stage.
  assign step     = q_valid && (!out_valid_r || out_pop);
  assign is_read  = q_info.kind == CMD_READ;
  assign is_write = q_info.kind == CMD_WRITE;
  assign run_last = idx_r == q_info.count - AMOUNT_W'(1);
  assign raddr    = q_addr + AW'(idx_r);
  assign q_pop    = step && (!is_read || run_last);

  always_comb begin
    idx_nxt = idx_r;
    if (step && is_read) begin
      idx_nxt = run_last ? '0 : idx_r + AMOUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (step && is_write) begin
      mem[q_addr] <= q_info.data;
    end
    if (step && is_read) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      ok_r       <= q_info.ok;
      has_data_r <= is_read;
      last_r     <= !is_read || run_last;
      fill_r     <= q_info.fill;
      free_r     <= q_info.free;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_empty      = !out_valid_r;
  assign out_ok         = ok_r;
  assign out_has_data   = has_data_r;
  assign out_read_byte  = has_data_r ? rdata_r : '0;
  assign out_last       = last_r;
  assign out_fill_level = fill_r;
  assign out_free_space = free_r;

endmodule

// ===== rtl/core/pow2_byte_ring_buffer.sv =====
// Channel   Handshake            Payload
// input     in_push / in_full    in_func, in_data, in_amount
// result    out_empty / out_pop  out_ok, out_has_data, out_read_byte, out_last,
//                                out_fill_level, out_free_space
//
// Each input item is classified in the cycle it is taken; a put request, a
// reserved put byte, a zero-length or failed read yields one result, a peek or
// get of N bytes yields N, and a put byte with no reservation yields none.
// A first result passes through the command queue and the result register
// after its transaction is taken; results leave at one per cycle while each is
// popped, set by the single read port of the ring memory; a two-entry command
// queue lets the front keep taking items. Reset clears the indices, the pending
// put count and both queues. Unpopped results fill the queue and raise in_full.
module pow2_byte_ring_buffer #(
  parameter int DEPTH        = pbrb_pkg::DEPTH_DEFAULT,
  parameter int MAX_TRANSFER = pbrb_pkg::MAX_TRANSFER_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [pbrb_pkg::FUNC_W-1:0]     in_func,
  input  logic [pbrb_pkg::DATA_W-1:0]     in_data,
  input  logic [pbrb_pkg::AMOUNT_W-1:0]   in_amount,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic                            out_ok,
  output logic                            out_has_data,
  output logic [pbrb_pkg::DATA_W-1:0]     out_read_byte,
  output logic                            out_last,
  output logic [pbrb_pkg::LEVEL_W-1:0]    out_fill_level,
  output logic [pbrb_pkg::LEVEL_W-1:0]    out_free_space
);
  import pbrb_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic          f_push, f_full;
  cmd_info_t     f_info;
  logic [AW-1:0] f_addr;
  logic          b_valid, b_pop;
  cmd_info_t     b_info;
  logic [AW-1:0] b_addr;

  pbrb_front #(
    .DEPTH(DEPTH),
    .MAX_TRANSFER(MAX_TRANSFER),
    .AW(AW)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_func(in_func),
    .in_data(in_data),
    .in_amount(in_amount),
    .q_push(f_push),
    .q_full(f_full),
    .q_info(f_info),
    .q_addr(f_addr)
  );

  pbrb_cmd_queue #(
    .AW(AW)
  ) u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(f_push),
    .full(f_full),
    .push_info(f_info),
    .push_addr(f_addr),
    .valid(b_valid),
    .pop(b_pop),
    .head_info(b_info),
    .head_addr(b_addr)
  );

  pbrb_back #(
    .DEPTH(DEPTH),
    .AW(AW)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_valid(b_valid),
    .q_pop(b_pop),
    .q_info(b_info),
    .q_addr(b_addr),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_ok(out_ok),
    .out_has_data(out_has_data),
    .out_read_byte(out_read_byte),
    .out_last(out_last),
    .out_fill_level(out_fill_level),
    .out_free_space(out_free_space)
  );

endmodule

// ===== rtl/core/pbrb_checker.sv =====
module pbrb_checker #(
  parameter int DEPTH = pbrb_pkg::DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            out_empty,
  input  logic                            out_pop,
  input  logic                            out_ok,
  input  logic                            out_has_data,
  input  logic [pbrb_pkg::DATA_W-1:0]     out_read_byte,
  input  logic                            out_last,
  input  logic [pbrb_pkg::LEVEL_W-1:0]    out_fill_level,
  input  logic [pbrb_pkg::LEVEL_W-1:0]    out_free_space
);
  import pbrb_pkg::*;

  localparam logic [LEVEL_W-1:0] LEVEL_SUM = LEVEL_W'(DEPTH - 1);

  // Fill and free space always add up to the ring size less the spare slot.
  a_level_sum: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> LEVEL_W'(out_fill_level + out_free_space) == LEVEL_SUM)
    else $error("fill plus free space does not match the ring size");

  a_refused_single: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_ok |-> out_last && !out_has_data)
    else $error("refused transaction is not a single final result");

  a_no_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_has_data |-> out_read_byte == '0)
    else $error("read byte is nonzero on a result without data");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_read_byte)
      && $stable(out_last) && $stable(out_fill_level))
    else $error("waiting result changed before it was taken");

endmodule

bind pow2_byte_ring_buffer pbrb_checker #(.DEPTH(DEPTH)) u_pbrb_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_empty(out_empty),
  .out_pop(out_pop),
  .out_ok(out_ok),
  .out_has_data(out_has_data),
  .out_read_byte(out_read_byte),
  .out_last(out_last),
  .out_fill_level(out_fill_level),
  .out_free_space(out_free_space)
);
